/* src/tricc_pkg.sv */
// ----------------------------------------------------------------------------
// tricc_pkg
// Shared flag types for the triangle circumcenter pipeline.
// ----------------------------------------------------------------------------
package tricc_pkg;

  // per-triangle side info produced by the determinant front end
  typedef struct packed {
    logic degen;
    logic neg_x;
    logic neg_y;
  } tricc_side_t;

  // side info plus quotient overflow, leaving the divider
  typedef struct packed {
    tricc_side_t side;
    logic        ovf_x;
    logic        ovf_y;
  } tricc_qflags_t;

endpackage

/* src/triangle_circumcenter_core.sv */
// ----------------------------------------------------------------------------
// triangle_circumcenter_core
// Circumcenter of a 2-D triangle in signed fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_ready with the three vertices ax, ay, bxin,
// byin, cxin, cyin. Output channel: out_valid/out_ready with center_x,
// center_y, degenerate and clipped.
// Throughput is one triangle per cycle while the receiver keeps up. The
// pipeline holds five determinant stages, one overflow stage plus one
// quotient bit per stage in the divider, and the output register.
// Collinear vertices give zero coordinates with degenerate set. A center
// beyond the coordinate range saturates to the nearer limit, clipped set.
// Reset empties the pipeline; payload registers keep whatever they hold.
// When the receiver stalls, words close up behind the output register
// into any empty stages; in_ready drops only when every stage is full.
// ----------------------------------------------------------------------------
module triangle_circumcenter_core #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] ax,
  input  logic signed [COORD_WIDTH-1:0] ay,
  input  logic signed [COORD_WIDTH-1:0] bxin,
  input  logic signed [COORD_WIDTH-1:0] byin,
  input  logic signed [COORD_WIDTH-1:0] cxin,
  input  logic signed [COORD_WIDTH-1:0] cyin,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] center_x,
  output logic signed [COORD_WIDTH-1:0] center_y,
  output logic                          degenerate,
  output logic                          clipped
);
  import tricc_pkg::*;

  localparam int W = COORD_WIDTH;
  localparam logic [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};

  logic [3*W+1:0] num_x;
  logic [3*W+1:0] num_y;
  logic [2*W+1:0] den;
  tricc_side_t    side;
  logic           det_valid;
  logic           det_ready;
  logic           div_valid;
  logic           div_ready;
  logic [W-1:0]   quo_x;
  logic [W-1:0]   quo_y;
  tricc_qflags_t  qfl;

  tricc_det #(.W(W)) u_det (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .ax        (ax),
    .ay        (ay),
    .bxin      (bxin),
    .byin      (byin),
    .cxin      (cxin),
    .cyin      (cyin),
    .out_valid (det_valid),
    .out_ready (det_ready),
    .num_x     (num_x),
    .num_y     (num_y),
    .den       (den),
    .side      (side)
  );

  tricc_div #(.W(W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (det_valid),
    .in_ready  (det_ready),
    .num_x     (num_x),
    .num_y     (num_y),
    .den       (den),
    .side      (side),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .quo_x     (quo_x),
    .quo_y     (quo_y),
    .flags     (qfl)
  );

  assign div_ready = ~out_valid | out_ready;

  // saturate and apply sign
  logic [W-1:0] lim_x;
  logic [W-1:0] lim_y;
  logic         clip_x;
  logic         clip_y;
  logic [W-1:0] mag_x;
  logic [W-1:0] mag_y;

  always_comb begin
    lim_x  = qfl.side.neg_x ? CMIN : CMAX;
    lim_y  = qfl.side.neg_y ? CMIN : CMAX;
    clip_x = qfl.ovf_x | (quo_x > lim_x);
    clip_y = qfl.ovf_y | (quo_y > lim_y);
    mag_x  = clip_x ? lim_x : quo_x;
    mag_y  = clip_y ? lim_y : quo_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (div_ready) begin
      out_valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (div_ready) begin
      if (qfl.side.degen) begin
        center_x   <= '0;
        center_y   <= '0;
        degenerate <= 1'b1;
        clipped    <= 1'b0;
      end else begin
        center_x   <= signed'(qfl.side.neg_x ? -mag_x : mag_x);
        center_y   <= signed'(qfl.side.neg_y ? -mag_y : mag_y);
        degenerate <= 1'b0;
        clipped    <= clip_x | clip_y;
      end
    end
  end

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> center_x == '0 && center_y == '0 && !clipped)
    else $error("degenerate word carries nonzero center or clip");

  a_clip_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |->
      unsigned'(center_x) == CMAX || unsigned'(center_x) == CMIN ||
      unsigned'(center_y) == CMAX || unsigned'(center_y) == CMIN)
    else $error("clipped word has no coordinate at a range limit");

  a_ready_empty: assert property (@(posedge clk)
    !out_valid |-> in_ready)
    else $error("input stalled while output register is empty");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

/* src/tricc_det.sv */
// ----------------------------------------------------------------------------
// tricc_det
// Five-stage front end: differences, squared norms, the three determinants,
// then rounding dividends and the divisor in magnitude form.
// ----------------------------------------------------------------------------
module tricc_det #(
  parameter int W = 24
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [W-1:0]      ax,
  input  logic signed [W-1:0]      ay,
  input  logic signed [W-1:0]      bxin,
  input  logic signed [W-1:0]      byin,
  input  logic signed [W-1:0]      cxin,
  input  logic signed [W-1:0]      cyin,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [3*W+1:0]           num_x,
  output logic [3*W+1:0]           num_y,
  output logic [2*W+1:0]           den,
  output tricc_pkg::tricc_side_t   side
);
  import tricc_pkg::*;

  localparam int DW = W + 1;
  localparam int NW = 2 * W;
  localparam int QW = 2 * W + 1;
  localparam int PW = 2 * W + 2;
  localparam int AW = 2 * W + 2;
  localparam int MW = 3 * W + 2;
  localparam int NS = 5;
  localparam int NXT [3] = '{1, 2, 0};
  localparam int PRV [3] = '{2, 0, 1};

  logic [NS-1:0] v;
  logic [NS-1:0] en;

  // a stage loads when the output moves on or when it or any stage after it has a hole
  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = out_ready | ~(&v[NS-1:k]);
  end

  assign in_ready  = en[0];
  assign out_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // stage 1: differences and squares
  logic signed [W-1:0]  xin [3];
  logic signed [W-1:0]  yin [3];
  logic signed [NW-1:0] xsq_c [3];
  logic signed [NW-1:0] ysq_c [3];
  logic signed [W-1:0]  x1 [3];
  logic signed [DW-1:0] xd1 [3];
  logic signed [DW-1:0] yd1 [3];
  logic [NW-1:0]        xs1 [3];
  logic [NW-1:0]        ys1 [3];

  assign xin[0] = ax;
  assign xin[1] = bxin;
  assign xin[2] = cxin;
  assign yin[0] = ay;
  assign yin[1] = byin;
  assign yin[2] = cyin;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      xsq_c[i] = NW'(xin[i]) * NW'(xin[i]);
      ysq_c[i] = NW'(yin[i]) * NW'(yin[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        x1[i]  <= xin[i];
        xd1[i] <= signed'({xin[NXT[i]][W-1], xin[NXT[i]]})
                - signed'({xin[PRV[i]][W-1], xin[PRV[i]]});
        yd1[i] <= signed'({yin[NXT[i]][W-1], yin[NXT[i]]})
                - signed'({yin[PRV[i]][W-1], yin[PRV[i]]});
        xs1[i] <= unsigned'(xsq_c[i]);
        ys1[i] <= unsigned'(ysq_c[i]);
      end
    end
  end

  // stage 2: norms and area terms
  logic [NW-1:0]        n2 [3];
  logic signed [QW-1:0] ap2 [3];
  logic signed [DW-1:0] xd2 [3];
  logic signed [DW-1:0] yd2 [3];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        n2[i]  <= xs1[i] + ys1[i];
        ap2[i] <= QW'(x1[i]) * QW'(yd1[i]);
        xd2[i] <= xd1[i];
        yd2[i] <= yd1[i];
      end
    end
  end

  // stage 3: area sum, norm products split in halves
  logic signed [DW-1:0] nlo_c [3];
  logic signed [DW-1:0] nhi_c [3];
  logic signed [AW-1:0] a3;
  logic signed [PW-1:0] pxl3 [3];
  logic signed [PW-1:0] pxh3 [3];
  logic signed [PW-1:0] pyl3 [3];
  logic signed [PW-1:0] pyh3 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nlo_c[i] = signed'({1'b0, n2[i][W-1:0]});
      nhi_c[i] = signed'({1'b0, n2[i][NW-1:W]});
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      a3 <= AW'(ap2[0]) + AW'(ap2[1]) + AW'(ap2[2]);
      for (int i = 0; i < 3; i++) begin
        pxl3[i] <= PW'(nlo_c[i]) * PW'(yd2[i]);
        pxh3[i] <= PW'(nhi_c[i]) * PW'(yd2[i]);
        pyl3[i] <= PW'(nlo_c[i]) * PW'(xd2[i]);
        pyh3[i] <= PW'(nhi_c[i]) * PW'(xd2[i]);
      end
    end
  end

  // stage 4: recombine halves into the x and negated y determinants
  logic signed [AW-1:0] a4;
  logic signed [MW-1:0] dx4;
  logic signed [MW-1:0] dyn4;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      a4   <= a3;
      dx4  <= (MW'(pxh3[0]) <<< W) + MW'(pxl3[0])
            + (MW'(pxh3[1]) <<< W) + MW'(pxl3[1])
            + (MW'(pxh3[2]) <<< W) + MW'(pxl3[2]);
      dyn4 <= MW'(0)
            - (MW'(pyh3[0]) <<< W) - MW'(pyl3[0])
            - (MW'(pyh3[1]) <<< W) - MW'(pyl3[1])
            - (MW'(pyh3[2]) <<< W) - MW'(pyl3[2]);
    end
  end

  // stage 5: magnitudes, rounding bias and divisor 2|a|
  logic [MW-1:0] mx_c;
  logic [MW-1:0] my_c;
  logic [AW-1:0] ma_c;

  always_comb begin
    mx_c = dx4[MW-1]  ? unsigned'(-dx4)  : unsigned'(dx4);
    my_c = dyn4[MW-1] ? unsigned'(-dyn4) : unsigned'(dyn4);
    ma_c = a4[AW-1]   ? unsigned'(-a4)   : unsigned'(a4);
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      num_x      <= mx_c + MW'(ma_c);
      num_y      <= my_c + MW'(ma_c);
      den        <= {ma_c[AW-2:0], 1'b0};
      side.degen <= (a4 == '0);
      side.neg_x <= dx4[MW-1] ^ a4[AW-1];
      side.neg_y <= dyn4[MW-1] ^ a4[AW-1];
    end
  end

endmodule

/* src/tricc_div.sv */
// ----------------------------------------------------------------------------
// tricc_div
// Two-lane pipelined restoring divider: one overflow stage, then one
// quotient bit per stage for W stages.
// ----------------------------------------------------------------------------
module tricc_div #(
  parameter int W = 24
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [3*W+1:0]           num_x,
  input  logic [3*W+1:0]           num_y,
  input  logic [2*W+1:0]           den,
  input  tricc_pkg::tricc_side_t   side,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [W-1:0]             quo_x,
  output logic [W-1:0]             quo_y,
  output tricc_pkg::tricc_qflags_t flags
);
  import tricc_pkg::*;

  localparam int MW = 3 * W + 2;
  localparam int DNW = 2 * W + 2;
  localparam int NS = W + 1;

  logic [NS-1:0] v;
  logic [NS-1:0] en;

  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = out_ready | ~(&v[NS-1:k]);
  end

  assign in_ready  = en[0];
  assign out_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  logic [MW-1:0]  rx [W];
  logic [MW-1:0]  ry [W];
  logic [DNW-1:0] d  [W];
  logic [W-1:0]   qx [NS];
  logic [W-1:0]   qy [NS];
  tricc_qflags_t  fl [NS];

  // stage 0: quotient reaches 2^W exactly when num >= den * 2^W
  always_ff @(posedge clk) begin
    if (en[0]) begin
      rx[0]       <= num_x;
      ry[0]       <= num_y;
      d[0]        <= den;
      qx[0]       <= '0;
      qy[0]       <= '0;
      fl[0].side  <= side;
      fl[0].ovf_x <= (num_x[MW-1:W] >= den);
      fl[0].ovf_y <= (num_y[MW-1:W] >= den);
    end
  end

  for (genvar s = 1; s < NS; s++) begin : g_step
    localparam int K = W - s;
    logic [MW-1:0] dsh;
    logic          gex;
    logic          gey;

    assign dsh = MW'(d[s-1]) << K;
    assign gex = (rx[s-1] >= dsh);
    assign gey = (ry[s-1] >= dsh);

    always_ff @(posedge clk) begin
      if (en[s]) begin
        qx[s] <= {qx[s-1][W-2:0], gex};
        qy[s] <= {qy[s-1][W-2:0], gey};
        fl[s] <= fl[s-1];
      end
    end

    if (s < W) begin : g_rem
      always_ff @(posedge clk) begin
        if (en[s]) begin
          rx[s] <= gex ? rx[s-1] - dsh : rx[s-1];
          ry[s] <= gey ? ry[s-1] - dsh : ry[s-1];
          d[s]  <= d[s-1];
        end
      end
    end
  end

  assign quo_x = qx[NS-1];
  assign quo_y = qy[NS-1];
  assign flags = fl[NS-1];

endmodule

/* bench/tb_triangle_circumcenter_core.sv */
// ----------------------------------------------------------------------------
// tb_triangle_circumcenter_core
// Self-checking bench for the triangle circumcenter pipeline.
// ----------------------------------------------------------------------------
// Directed triangles cover the coordinate extremes, collinear and coincident
// vertices, and centers that saturate. Random triangles follow: full-range
// words, small well-formed triangles, exactly collinear sets, near-flat
// slivers and sets with two coincident vertices. Each accepted triangle is
// run through an exact wide-integer model of the circumcenter. The expected
// words are queued in order and compared field by field with every word
// taken from the output. Random gaps and stalls are applied on both channels.
// ----------------------------------------------------------------------------
module tb_triangle_circumcenter_core;

  localparam int CW        = 24;
  localparam int MAX_CYCLE = 1000000;
  localparam int N_RANDOM  = 1330;
  localparam int DRAIN     = 60;

  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] ONE  = 24'sd4096;

  typedef struct {
    logic signed [CW-1:0] x0, y0, x1, y1, x2, y2;
  } triangle_t;

  typedef struct {
    logic signed [CW-1:0] cx, cy;
    logic                 degen, clip;
  } center_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CW-1:0] ax = '0, ay = '0, bxin = '0, byin = '0, cxin = '0, cyin = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [CW-1:0] center_x, center_y;
  logic degenerate, clipped;

  triangle_t triangles_pending[$];
  center_t   centers_expected[$];
  int        n_errors = 0;
  int        cycle = 0;
  int        send_gap = 0;
  int        recv_gap = 0;
  bit        calm = 1'b0;

  triangle_circumcenter_core #(.COORD_WIDTH(CW)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .ax(ax), .ay(ay), .bxin(bxin), .byin(byin), .cxin(cxin), .cyin(cyin),
    .out_valid(out_valid), .out_ready(out_ready),
    .center_x(center_x), .center_y(center_y),
    .degenerate(degenerate), .clipped(clipped)
  );

  always #5 clk = ~clk;

  // rounded, saturated num / (2*den); den nonzero
  function automatic logic signed [CW-1:0] round_div(input logic signed [127:0] num,
                                                     input logic signed [127:0] den,
                                                     inout logic clip);
    logic neg;
    logic [127:0] mn, md, q, lim;
    neg = (num < 0) != (den < 0);
    mn  = (num < 0) ? -num : num;
    md  = (den < 0) ? -den : den;
    q   = (mn + md) / (md << 1);
    lim = (128'd1 << (CW - 1)) - (neg ? 128'd0 : 128'd1);
    if (q > lim) begin
      clip = 1'b1;
      q = lim;
    end
    return neg ? CW'(-q) : CW'(q);
  endfunction

  function automatic center_t circumcenter(input triangle_t t);
    logic signed [127:0] x0, y0, x1, y1, x2, y2, n0, n1, n2, area2, detx, dety;
    center_t r;
    x0 = 128'(t.x0); y0 = 128'(t.y0); x1 = 128'(t.x1);
    y1 = 128'(t.y1); x2 = 128'(t.x2); y2 = 128'(t.y2);
    n0 = x0 * x0 + y0 * y0;
    n1 = x1 * x1 + y1 * y1;
    n2 = x2 * x2 + y2 * y2;
    area2 = x0 * (y1 - y2) + x1 * (y2 - y0) + x2 * (y0 - y1);
    detx  = n0 * (y1 - y2) + n1 * (y2 - y0) + n2 * (y0 - y1);
    dety  = n0 * (x1 - x2) + n1 * (x2 - x0) + n2 * (x0 - x1);
    r.cx = '0; r.cy = '0; r.clip = 1'b0; r.degen = 1'b0;
    if (area2 == 0) begin
      r.degen = 1'b1;
    end else begin
      r.cx = round_div(detx, area2, r.clip);
      r.cy = round_div(-dety, area2, r.clip);
    end
    return r;
  endfunction

  function automatic logic signed [CW-1:0] rand_coord(input int span);
    return CW'($signed({1'b0, $urandom_range(2 * span, 0)}) - span);
  endfunction

  function automatic logic signed [CW-1:0] rand_word();
    return CW'($urandom);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (calm || r < 65) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 5);
  endfunction

  task automatic report_mismatch(input string field, input longint want, input longint got);
    $display("mismatch %s: expected %0d got %0d at cycle %0d", field, want, got, cycle);
    n_errors++;
  endtask

  task automatic add_tri(input logic signed [CW-1:0] a0, b0, a1, b1, a2, b2);
    triangle_t t;
    t.x0 = a0; t.y0 = b0; t.x1 = a1; t.y1 = b1; t.x2 = a2; t.y2 = b2;
    triangles_pending.push_back(t);
  endtask

  // send side: hold the word until taken, then load the next or idle
  always @(posedge clk) begin
    triangle_t t;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid)
        centers_expected.push_back(circumcenter('{ax, ay, bxin, byin, cxin, cyin}));
      if (send_gap > 0 || triangles_pending.size() == 0) begin
        if (send_gap > 0) send_gap--;
        in_valid <= 1'b0;
      end else begin
        t = triangles_pending.pop_front();
        ax <= t.x0; ay <= t.y0; bxin <= t.x1; byin <= t.y1; cxin <= t.x2; cyin <= t.y2;
        in_valid <= 1'b1;
        send_gap = pick_gap();
      end
    end
  end

  // receive side: check each word taken, then stall at random
  always @(posedge clk) begin
    center_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (centers_expected.size() == 0) begin
          $display("unexpected word at cycle %0d", cycle);
          n_errors++;
        end else begin
          e = centers_expected.pop_front();
          if (center_x !== e.cx) report_mismatch("center_x", e.cx, center_x);
          if (center_y !== e.cy) report_mismatch("center_y", e.cy, center_y);
          if (degenerate !== e.degen) report_mismatch("degenerate", e.degen, degenerate);
          if (clipped !== e.clip) report_mismatch("clipped", e.clip, clipped);
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        recv_gap = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= MAX_CYCLE) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic signed [CW-1:0] px, py, dx, dy;
    int k, kind;

    // directed: degenerate, extremes, saturation, plain triangles
    add_tri('0, '0, '0, '0, '0, '0);
    add_tri(ONE, ONE, ONE, ONE, -ONE, ONE);
    add_tri('0, '0, ONE, ONE, CW'(2 * ONE), CW'(2 * ONE));
    add_tri('0, '0, ONE, '0, '0, ONE);
    add_tri(-ONE, -ONE, ONE, -ONE, -ONE, ONE);
    add_tri(CMAX, CMAX, CMIN, CMAX, CMAX, CMIN);
    add_tri(CMIN, CMIN, CMAX, CMIN, CMIN, CMAX);
    add_tri(CMAX, CMAX, CMAX, CMAX, CMIN, CMIN);
    add_tri(CMIN, '0, CMAX, '0, '0, CMAX);
    add_tri('0, CMIN, '0, CMAX, CMAX, '0);
    add_tri('0, '0, ONE, '0, CW'(2 * ONE), 24'sd1);
    add_tri('0, '0, ONE, '0, CW'(2 * ONE), -24'sd1);
    add_tri('0, '0, 24'sd1, '0, '0, 24'sd1);
    add_tri(24'sd1, 24'sd2, 24'sd3, 24'sd5, 24'sd7, 24'sd4);
    add_tri(CMAX, '0, CW'(CMAX - 1), 24'sd1, CMAX, 24'sd2);
    add_tri(CMIN, CMIN, CW'(CMIN + 1), CMIN, CMIN, CW'(CMIN + 1));
    add_tri(CW'(3 * ONE), ONE, -ONE, CW'(2 * ONE), ONE, CW'(-4 * ONE));
    add_tri(-24'sd1, -24'sd1, -24'sd1, -24'sd1, -24'sd1, -24'sd1);
    add_tri(CMAX, CMIN, CMAX, CMIN, '0, '0);
    add_tri(24'h555555, 24'haaaaaa, 24'haaaaaa, 24'h555555, 24'h0f0f0f, 24'hf0f0f0);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 150 == 0) calm = ($urandom_range(3) == 0);
      kind = $urandom_range(9);
      case (kind)
        0, 1: begin
          add_tri(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
        end
        2: begin
          // exactly collinear
          px = rand_coord(1 << 20); py = rand_coord(1 << 20);
          dx = rand_coord(1 << 10); dy = rand_coord(1 << 10);
          k = $urandom_range(6) - 3;
          add_tri(px, py, px + dx, py + dy, CW'(px + k * dx), CW'(py + k * dy));
        end
        3: begin
          // near-flat sliver
          px = rand_coord(1 << 18); py = rand_coord(1 << 18);
          dx = rand_coord(1 << 12); dy = rand_coord(1 << 12);
          add_tri(px, py, px + dx, py + dy, CW'(px + 2 * dx + rand_coord(2)),
                  CW'(py + 2 * dy + rand_coord(2)));
        end
        4: begin
          px = rand_coord(1 << 16); py = rand_coord(1 << 16);
          add_tri(px, py, px, py, rand_coord(1 << 16), rand_coord(1 << 16));
        end
        default: begin
          // well-formed mesh triangle around a random point
          px = rand_coord(1 << 22); py = rand_coord(1 << 22);
          add_tri(px + rand_coord(1 << 14), py + rand_coord(1 << 14),
                  px + rand_coord(1 << 14), py + rand_coord(1 << 14),
                  px + rand_coord(1 << 14), py + rand_coord(1 << 14));
        end
      endcase
    end
    calm = 1'b0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    wait (triangles_pending.size() == 0 && !in_valid && centers_expected.size() == 0);
    repeat (DRAIN) @(posedge clk);
    if (n_errors == 0 && centers_expected.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* triangle_circumcenter_core.f */
src/tricc_pkg.sv
src/tricc_det.sv
src/tricc_div.sv
src/triangle_circumcenter_core.sv
bench/tb_triangle_circumcenter_core.sv
